@@ src/arp_cache_with_oldest_replacement_unit_assert.svh @@
// assertion macros used by the arp cache rtl
`ifndef ARP_CACHE_WITH_OLDEST_REPLACEMENT_UNIT_ASSERT_SVH
`define ARP_CACHE_WITH_OLDEST_REPLACEMENT_UNIT_ASSERT_SVH

// same-cycle implication
`define ARPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("arpc assertion failed");

// next-cycle implication
`define ARPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("arpc assertion failed");

`endif

@@ src/arpc_pkg.sv @@
// shared types and constants of the arp cache
package arpc_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned OP_W   = 16;
  localparam int unsigned LEN_W  = 16;

  localparam logic [TIME_W-1:0] TIME_CEILING   = 32'hFFFF_FFFF;
  localparam logic [OP_W-1:0]   REQUEST_OPCODE = 16'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_PACKET = 2'd2
  } cmd_e;

  typedef struct packed {
    logic match;
    logic free;
    logic old;
  } scan_flags_t;

endpackage

@@ src/arp_cache_with_oldest_replacement_unit.sv @@
// arp cache with oldest-entry replacement, top level
// An item passes through these steps before the next input transfer: an idle
// state that takes the item, a scan state that reads one table entry per cycle
// while the single read port of the table feeds the shared scan unit, a drain
// state for the last read to land in the scan unit, and a commit state that writes
// the table and loads the result register. The commit waits while an earlier
// result is still held in the output register. Lookups, inserts and packets all
// take the full scan. Valid bits clear at reset; there is no clearing pass.
`include "arp_cache_with_oldest_replacement_unit_assert.svh"

module arp_cache_with_oldest_replacement_unit #(
  parameter int unsigned TABLE_ENTRIES    = 16,
  parameter int unsigned MIN_PACKET_BYTES = 28
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [arpc_pkg::IP_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [arpc_pkg::CMD_W-1:0]  command_i,
  input  logic [arpc_pkg::IP_W-1:0]   ip_address_i,
  input  logic [arpc_pkg::MAC_W-1:0]  mac_address_i,
  input  logic [arpc_pkg::IP_W-1:0]   target_ip_i,
  input  logic [arpc_pkg::OP_W-1:0]   arp_operation_i,
  input  logic [arpc_pkg::LEN_W-1:0]  packet_length_i,
  input  logic [arpc_pkg::TIME_W-1:0] current_time_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [arpc_pkg::MAC_W-1:0]  found_mac_o,
  output logic                        reply_valid_o,
  output logic [arpc_pkg::IP_W-1:0]   reply_ip_o,
  output logic [arpc_pkg::MAC_W-1:0]  reply_mac_o
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [LEN_W-1:0] MIN_LEN  = LEN_W'(MIN_PACKET_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [IP_W-1:0]   own_ip_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [IP_W-1:0]   ip_q, tip_q;
  logic [MAC_W-1:0]  mac_q;
  logic [OP_W-1:0]   op_q;
  logic [LEN_W-1:0]  len_q;
  logic [TIME_W-1:0] now_q;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [IP_W-1:0]   mem_ip_q   [TABLE_ENTRIES];
  logic [MAC_W-1:0]  mem_mac_q  [TABLE_ENTRIES];
  logic [TIME_W-1:0] mem_time_q [TABLE_ENTRIES];

  logic [IDX_W-1:0]  rd_idx, rd_idx_q;
  logic              rd_v_q, rd_vld_q;
  logic [IP_W-1:0]   rd_ip_q;
  logic [MAC_W-1:0]  rd_mac_q;
  logic [TIME_W-1:0] rd_time_q;

  scan_flags_t      flags;
  logic [IDX_W-1:0] match_idx, free_idx, old_idx;
  logic [MAC_W-1:0] match_mac;

  logic in_xfer, commit, do_insert, do_reply, we_all, we_upd;
  logic [IDX_W-1:0] wr_idx;

  logic              out_valid_q, hit_q, reply_valid_q;
  logic [MAC_W-1:0]  found_mac_q, reply_mac_q;
  logic [IP_W-1:0]   reply_ip_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign commit      = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);
  assign rd_idx      = cnt_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else if (cfg_valid_i) begin
      own_ip_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= command_i;
      ip_q  <= ip_address_i;
      mac_q <= mac_address_i;
      tip_q <= target_ip_i;
      op_q  <= arp_operation_i;
      len_q <= packet_length_i;
      now_q <= current_time_i;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_xfer) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == LAST_CNT) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_v_q  <= (state_q == ST_SCAN);
    end
  end

  // table read port
  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx;
    rd_vld_q  <= valid_q[rd_idx];
    rd_ip_q   <= mem_ip_q[rd_idx];
    rd_mac_q  <= mem_mac_q[rd_idx];
    rd_time_q <= mem_time_q[rd_idx];
  end

  arpc_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (in_xfer),
    .sample_i    (rd_v_q),
    .smp_valid_i (rd_vld_q),
    .smp_ip_i    (rd_ip_q),
    .smp_mac_i   (rd_mac_q),
    .smp_time_i  (rd_time_q),
    .smp_idx_i   (rd_idx_q),
    .key_ip_i    (ip_q),
    .flags_o     (flags),
    .match_idx_o (match_idx),
    .match_mac_o (match_mac),
    .free_idx_o  (free_idx),
    .old_idx_o   (old_idx)
  );

  // commit decision
  assign do_insert = (cmd_q == CMD_INSERT) || ((cmd_q == CMD_PACKET) && (len_q >= MIN_LEN));
  assign do_reply  = (cmd_q == CMD_PACKET) && (len_q >= MIN_LEN) &&
                     (op_q == REQUEST_OPCODE) && (tip_q == own_ip_q);
  assign we_upd    = commit && do_insert && flags.match;
  assign we_all    = commit && do_insert && !flags.match && (flags.free || flags.old);

  always_comb begin
    if (flags.match) begin
      wr_idx = match_idx;
    end else if (flags.free) begin
      wr_idx = free_idx;
    end else begin
      wr_idx = old_idx;
    end
  end

  // table write port
  always_ff @(posedge clk_i) begin
    if (we_all || we_upd) begin
      mem_mac_q[wr_idx]  <= mac_q;
      mem_time_q[wr_idx] <= now_q;
    end
    if (we_all) begin
      mem_ip_q[wr_idx] <= ip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_all) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q         <= (cmd_q == CMD_LOOKUP) && flags.match;
      found_mac_q   <= ((cmd_q == CMD_LOOKUP) && flags.match) ? match_mac : '0;
      reply_valid_q <= do_reply;
      reply_ip_q    <= do_reply ? ip_q : '0;
      reply_mac_q   <= do_reply ? mac_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign found_mac_o   = found_mac_q;
  assign reply_valid_o = reply_valid_q;
  assign reply_ip_o    = reply_ip_q;
  assign reply_mac_o   = reply_mac_q;

  `ARPC_ASSERT_NEXT(a_xfer_starts_scan, in_xfer, (state_q == ST_SCAN) && (cnt_q == '0))
  `ARPC_ASSERT_NEXT(a_result_held, out_valid_o && !out_ready_i, out_valid_o && $stable(found_mac_o))
  `ARPC_ASSERT_NOW(a_hit_excl_reply, out_valid_o && reply_valid_o, !hit_o)
  `ARPC_ASSERT_NOW(a_write_one_kind, we_all || we_upd, !(we_all && we_upd))
  `ARPC_ASSERT_NEXT(a_commit_shows_result, commit, out_valid_o)

endmodule

@@ src/arpc_scan.sv @@
// table scan unit: first match, first free slot and oldest entry
module arpc_scan #(
  parameter int unsigned IDX_W = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        sample_i,
  input  logic                        smp_valid_i,
  input  logic [arpc_pkg::IP_W-1:0]   smp_ip_i,
  input  logic [arpc_pkg::MAC_W-1:0]  smp_mac_i,
  input  logic [arpc_pkg::TIME_W-1:0] smp_time_i,
  input  logic [IDX_W-1:0]            smp_idx_i,
  input  logic [arpc_pkg::IP_W-1:0]   key_ip_i,
  output arpc_pkg::scan_flags_t       flags_o,
  output logic [IDX_W-1:0]            match_idx_o,
  output logic [arpc_pkg::MAC_W-1:0]  match_mac_o,
  output logic [IDX_W-1:0]            free_idx_o,
  output logic [IDX_W-1:0]            old_idx_o
);
  import arpc_pkg::*;

  scan_flags_t       flags_q, flags_d;
  logic [IDX_W-1:0]  match_idx_q, free_idx_q, old_idx_q;
  logic [MAC_W-1:0]  match_mac_q;
  logic [TIME_W-1:0] oldest_q;
  logic              hit_now, free_now, older_now;

  assign hit_now   = sample_i && smp_valid_i && (smp_ip_i == key_ip_i) && !flags_q.match;
  assign free_now  = sample_i && !smp_valid_i && !flags_q.free;
  assign older_now = sample_i && smp_valid_i && (smp_time_i < oldest_q);

  always_comb begin
    flags_d = flags_q;
    if (clear_i) begin
      flags_d = '0;
    end else begin
      if (hit_now) flags_d.match = 1'b1;
      if (free_now) flags_d.free = 1'b1;
      if (older_now) flags_d.old = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      oldest_q <= TIME_CEILING;
    end else begin
      if (hit_now) begin
        match_idx_q <= smp_idx_i;
        match_mac_q <= smp_mac_i;
      end
      if (free_now) free_idx_q <= smp_idx_i;
      if (older_now) begin
        oldest_q  <= smp_time_i;
        old_idx_q <= smp_idx_i;
      end
    end
  end

  assign flags_o     = flags_q;
  assign match_idx_o = match_idx_q;
  assign match_mac_o = match_mac_q;
  assign free_idx_o  = free_idx_q;
  assign old_idx_o   = old_idx_q;

endmodule
